@@ hdl/bit_sliced_bloom_filter_macros.svh @@
// ----------------------------------------------------------------------------
// bit_sliced_bloom_filter_macros
// Assertion macros for the bit-sliced Bloom filter; each expects aclk and
// aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef BIT_SLICED_BLOOM_FILTER_MACROS_SVH
`define BIT_SLICED_BLOOM_FILTER_MACROS_SVH

// same-cycle implication
`define BSBF_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("bsbf: implication check failed");

// next-cycle implication
`define BSBF_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("bsbf: next-cycle check failed");

`endif

@@ hdl/bsbf_pkg.sv @@
// ----------------------------------------------------------------------------
// bsbf_pkg
// Shared types and constants of the bit-sliced Bloom filter.
// ----------------------------------------------------------------------------
package bsbf_pkg;

    localparam int KEY_BYTES = 8;
    localparam int CFG_W     = 13;
    localparam int HCNT_W    = 4;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 4'd1;

    localparam logic [CFG_W-1:0]  FILTER_ROWS_RST = 13'd4096;
    localparam logic [HCNT_W-1:0] HASH_COUNT_RST  = 4'd3;

    // XXH32 primes
    localparam logic [31:0] PR2 = 32'd2246822519;
    localparam logic [31:0] PR3 = 32'd3266489917;
    localparam logic [31:0] PR4 = 32'd668265263;
    localparam logic [31:0] PR5 = 32'd374761393;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HINIT,
        OP_HR0,
        OP_HP1,
        OP_HR1,
        OP_HF1,
        OP_HF2,
        OP_HF3,
        OP_MSTEP,
        OP_MRD,
        OP_MWR,
        OP_CLR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
        logic   seed_clr;
        logic   seed_inc;
        logic   out_load;
        logic   out_val;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic col_ok;
        logic n_zero;
        logic last_seed;
        logic mod_done;
        logic bit_set;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ hdl/bit_sliced_bloom_filter.sv @@
// ----------------------------------------------------------------------------
// bit_sliced_bloom_filter
// Bit-sliced Bloom filter matrix addressed by seeded XXH32 of a 64-bit key.
// ----------------------------------------------------------------------------
// One word in carries an operation, a key and a column. For every seed up to
// hash_count-1 the row is XXH32(key, seed) mod filter_rows (hash_count capped
// at MAX_HASHES, filter_rows at ROWS, zero taken as 1); an insert sets the
// column bit in each row, a query returns one word with present set when all
// addressed bits are set (it stops at the first clear bit). Each seed takes 7
// hash steps with at most one 32 by 32 constant multiply each, 8 modulo steps
// at 4 quotient bits each, a registered matrix read and a check or write-back;
// an invalid column or zero hash count skips these steps. A query result sits
// in an output register and the next word is taken while it waits; a second
// result stalls until that register has been read. After reset the matrix is
// cleared one row per cycle, all ROWS rows (4096 by default), during which
// s_ready is low; configuration writes are taken at any time.
module bit_sliced_bloom_filter import bsbf_pkg::*; #(
    parameter int ROWS        = 4096,
    parameter int BLOCK_BYTES = 8,
    parameter int MAX_HASHES  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [63:0]          s_key,
    input  logic [5:0]           s_column,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_present
);

`include "bit_sliced_bloom_filter_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // registers are always writable
    assign cfg_ready = 1'b1;

    bsbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bsbf_datapath #(
        .ROWS        (ROWS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_HASHES  (MAX_HASHES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_column    (s_column),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_present   (m_present)
    );

    // a pending result is never overwritten
    `BSBF_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_valid || m_ready)
    // no word taken while the clearing pass runs
    `BSBF_ASSERT_IMP(a_clear_blocks, cmd.op == OP_CLR, !s_ready)
    // one word at a time
    `BSBF_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

@@ hdl/bsbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsbf_ctrl
// Sequencer: clearing pass, hash steps, modulo, row read/update, response.
// ----------------------------------------------------------------------------
module bsbf_ctrl import bsbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_HINIT, ST_HR0, ST_HP1, ST_HR1,
        ST_HF1, ST_HF2, ST_HF3, ST_MOD, ST_MRD, ST_MCHK, ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   present_reg, present_next;

    always_comb begin
        state_next   = state_reg;
        present_next = present_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLR;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.seed_clr = 1'b1;
                if (!stat.col_ok || stat.n_zero) begin
                    present_next = stat.col_ok;
                    state_next   = stat.is_query ? ST_RESP : ST_IDLE;
                end else begin
                    state_next = ST_HINIT;
                end
            end
            ST_HINIT: begin cmd.op = OP_HINIT; state_next = ST_HR0; end
            ST_HR0:   begin cmd.op = OP_HR0;   state_next = ST_HP1; end
            ST_HP1:   begin cmd.op = OP_HP1;   state_next = ST_HR1; end
            ST_HR1:   begin cmd.op = OP_HR1;   state_next = ST_HF1; end
            ST_HF1:   begin cmd.op = OP_HF1;   state_next = ST_HF2; end
            ST_HF2:   begin cmd.op = OP_HF2;   state_next = ST_HF3; end
            ST_HF3:   begin cmd.op = OP_HF3;   state_next = ST_MOD; end
            ST_MOD: begin
                cmd.op = OP_MSTEP;
                if (stat.mod_done) state_next = ST_MRD;
            end
            ST_MRD: begin cmd.op = OP_MRD; state_next = ST_MCHK; end
            ST_MCHK: begin
                if (!stat.is_query) begin
                    cmd.op = OP_MWR;
                    if (stat.last_seed) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.seed_inc = 1'b1;
                        state_next   = ST_HINIT;
                    end
                end else if (!stat.bit_set || stat.last_seed) begin
                    present_next = stat.bit_set;
                    state_next   = ST_RESP;
                end else begin
                    cmd.seed_inc = 1'b1;
                    state_next   = ST_HINIT;
                end
            end
            ST_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_val  = present_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            present_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
        end
    end

endmodule

@@ hdl/bsbf_datapath.sv @@
// ----------------------------------------------------------------------------
// bsbf_datapath
// Config registers, XXH32 step unit, radix-16 modulo, bit matrix, result reg.
// ----------------------------------------------------------------------------
module bsbf_datapath import bsbf_pkg::*; #(
    parameter int ROWS        = 4096,
    parameter int BLOCK_BYTES = 8,
    parameter int MAX_HASHES  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_operation,
    input  logic [63:0]          s_key,
    input  logic [5:0]           s_column,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_present
);

    localparam int COLS  = 8 * BLOCK_BYTES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [CFG_W-1:0]  filter_rows_reg;
    logic [HCNT_W-1:0] hash_count_reg;
    logic              op_reg;
    logic [63:0]       key_reg;
    logic [5:0]        col_reg;
    logic [HCNT_W-1:0] seed_reg;
    logic [31:0]       h_reg, h_next, p_reg, p_next, sh_reg, sh_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [2:0]        mcnt_reg;
    logic [ROW_W-1:0]  clr_addr_reg;
    logic [COLS-1:0]   rdata_reg;
    logic              m_valid_reg, m_present_reg;

    logic [COLS-1:0]   mem [ROWS];

    logic [CFG_W-1:0]  modulus;
    logic [HCNT_W-1:0] n_eff;
    logic [COLS-1:0]   mask;
    logic [ROW_W-1:0]  row_addr;
    logic [31:0]       t;
    logic [CFG_W:0]    r;

    always_comb begin
        if (filter_rows_reg == '0) modulus = CFG_W'(1);
        else if (32'(filter_rows_reg) > 32'(ROWS)) modulus = CFG_W'(ROWS);
        else modulus = filter_rows_reg;
        n_eff = (32'(hash_count_reg) > 32'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES)
                                                       : hash_count_reg;
    end

    assign mask     = COLS'(1) << col_reg;
    assign row_addr = ROW_W'(rem_reg);

    // hash and modulo step
    always_comb begin
        h_next   = h_reg;
        p_next   = p_reg;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        t        = '0;
        r        = '0;
        unique case (cmd.op) inside
            OP_HINIT: begin
                h_next = 32'(seed_reg) + PR5 + 32'(KEY_BYTES);
                p_next = key_reg[31:0] * PR3;
            end
            OP_HR0, OP_HR1: begin
                t      = h_reg + p_reg;
                h_next = {t[14:0], t[31:15]} * PR4;
            end
            OP_HP1: p_next = key_reg[63:32] * PR3;
            OP_HF1: begin
                t      = h_reg ^ (h_reg >> 15);
                h_next = t * PR2;
            end
            OP_HF2: begin
                t      = h_reg ^ (h_reg >> 13);
                h_next = t * PR3;
            end
            OP_HF3: begin
                sh_next  = h_reg ^ (h_reg >> 16);
                rem_next = '0;
            end
            OP_MSTEP: begin
                r = {1'b0, rem_reg};
                for (int i = 0; i < 4; i++) begin
                    r = {r[CFG_W-1:0], sh_reg[31-i]};
                    if (r >= {1'b0, modulus}) r = r - {1'b0, modulus};
                end
                rem_next = r[CFG_W-1:0];
                sh_next  = {sh_reg[27:0], 4'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        h_reg   <= h_next;
        p_reg   <= p_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        if (cmd.op == OP_HF3) mcnt_reg <= '0;
        else if (cmd.op == OP_MSTEP) mcnt_reg <= mcnt_reg + 3'd1;
        if (cmd.load) begin
            op_reg  <= s_operation;
            key_reg <= s_key;
            col_reg <= s_column;
        end
        if (cmd.seed_clr) seed_reg <= '0;
        else if (cmd.seed_inc) seed_reg <= seed_reg + HCNT_W'(1);
    end

    // bit matrix: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CLR) mem[clr_addr_reg] <= '0;
        else if (cmd.op == OP_MWR) mem[row_addr] <= rdata_reg | mask;
        if (cmd.op == OP_MRD) rdata_reg <= mem[row_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_rows_reg <= FILTER_ROWS_RST;
            hash_count_reg  <= HASH_COUNT_RST;
            clr_addr_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FILTER_ROWS: filter_rows_reg <= cfg_data;
                    CFG_HASH_COUNT:  hash_count_reg  <= cfg_data[HCNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_CLR) clr_addr_reg <= clr_addr_reg + ROW_W'(1);
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_present_reg <= cmd.out_val;
    end

    always_comb begin
        stat.clr_last  = (clr_addr_reg == ROW_W'(ROWS - 1));
        stat.is_query  = op_reg;
        stat.col_ok    = (32'(col_reg) < 32'(COLS));
        stat.n_zero    = (n_eff == '0);
        stat.last_seed = (seed_reg == n_eff - HCNT_W'(1));
        stat.mod_done  = (mcnt_reg == 3'd7);
        stat.bit_set   = ((rdata_reg & mask) != '0);
        stat.out_busy  = m_valid_reg & ~m_ready;
    end

    assign m_valid   = m_valid_reg;
    assign m_present = m_present_reg;

endmodule
